[rtl/alarm_beep_pattern_generator_top_assert.svh]
// assertion macros for the alarm beep pattern generator
`ifndef ALARM_BEEP_PATTERN_GENERATOR_TOP_ASSERT_SVH
`define ALARM_BEEP_PATTERN_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define ABPG_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ABPG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define ABPG_ASSERT_NOW(label, clk, rst_n, pre, post, msg)
`define ABPG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

[rtl/abpg_pkg.sv]
// shared types and constants of the alarm beep pattern generator
`default_nettype none

package abpg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TICKS_W    = 16;
    localparam int BEEPS_W    = 4;
    localparam int FLIPS_W    = 5;
    localparam int LEVEL_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEPS_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEPS_MEDIUM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEPS_HIGH   = 3'd4;

    // configuration reset values
    localparam logic [TICKS_W-1:0] HALF_PERIOD_RST  = 16'd200;
    localparam logic [TICKS_W-1:0] PAUSE_RST        = 16'd1000;
    localparam logic [BEEPS_W-1:0] BEEPS_LOW_RST    = 4'd1;
    localparam logic [BEEPS_W-1:0] BEEPS_MEDIUM_RST = 4'd3;
    localparam logic [BEEPS_W-1:0] BEEPS_HIGH_RST   = 4'd5;

    // item function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_LEVEL = 1'b1;

    // alarm levels
    localparam logic [LEVEL_W-1:0] LEVEL_OFF    = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH   = 2'd3;

    typedef struct packed {
        logic               func;
        logic [LEVEL_W-1:0] new_level;
    } abpg_in_t;

    typedef struct packed {
        logic               buzzer_pin;
        logic [LEVEL_W-1:0] level_now;
        logic               in_pause;
    } abpg_out_t;

    typedef struct packed {
        logic [TICKS_W-1:0] half_period_ticks;
        logic [TICKS_W-1:0] pause_ticks;
        logic [BEEPS_W-1:0] beeps_low;
        logic [BEEPS_W-1:0] beeps_medium;
        logic [BEEPS_W-1:0] beeps_high;
    } abpg_cfg_t;

endpackage

`default_nettype wire

[rtl/abpg_cfg_regs.sv]
// configuration register file of the alarm beep pattern generator
`default_nettype none

module abpg_cfg_regs
    import abpg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output abpg_cfg_t                  cfg
);

    abpg_cfg_t cfg_reg;
    abpg_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_HALF_PERIOD:  cfg_next.half_period_ticks = wr_data[TICKS_W-1:0];
                CFG_PAUSE:        cfg_next.pause_ticks       = wr_data[TICKS_W-1:0];
                CFG_BEEPS_LOW:    cfg_next.beeps_low         = wr_data[BEEPS_W-1:0];
                CFG_BEEPS_MEDIUM: cfg_next.beeps_medium      = wr_data[BEEPS_W-1:0];
                CFG_BEEPS_HIGH:   cfg_next.beeps_high        = wr_data[BEEPS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RST;
            cfg_reg.pause_ticks       <= PAUSE_RST;
            cfg_reg.beeps_low         <= BEEPS_LOW_RST;
            cfg_reg.beeps_medium      <= BEEPS_MEDIUM_RST;
            cfg_reg.beeps_high        <= BEEPS_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/abpg_core.sv]
// beep pattern state and its per-item update
`default_nettype none

module abpg_core
    import abpg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire abpg_cfg_t cfg,
    input  wire logic      step,
    input  wire abpg_in_t  item,
    output abpg_out_t      result
);

    logic [LEVEL_W-1:0] level_reg,       level_next;
    logic               pause_reg,       pause_next;
    logic               tone_reg,        tone_next;
    logic               pin_reg,         pin_next;
    logic [TICKS_W-1:0] half_count_reg,  half_count_next;
    logic [FLIPS_W-1:0] flip_count_reg,  flip_count_next;
    logic [FLIPS_W-1:0] flip_limit_reg,  flip_limit_next;
    logic [TICKS_W-1:0] pause_count_reg, pause_count_next;

    logic [TICKS_W-1:0] half_count_inc;
    logic [TICKS_W-1:0] pause_count_inc;
    logic [FLIPS_W-1:0] flip_count_inc;
    logic [LEVEL_W-1:0] train_level;
    logic [BEEPS_W-1:0] train_beeps;

    assign half_count_inc  = half_count_reg + {{(TICKS_W-1){1'b0}}, 1'b1};
    assign pause_count_inc = pause_count_reg + {{(TICKS_W-1){1'b0}}, 1'b1};
    assign flip_count_inc  = flip_count_reg + {{(FLIPS_W-1){1'b0}}, 1'b1};

    // a level command restarts with its own level, a pause end with the stored one
    assign train_level = (item.func == FUNC_LEVEL) ? item.new_level : level_reg;

    always_comb
    begin
        case (train_level)
            LEVEL_LOW:    train_beeps = cfg.beeps_low;
            LEVEL_MEDIUM: train_beeps = cfg.beeps_medium;
            LEVEL_HIGH:   train_beeps = cfg.beeps_high;
            default:      train_beeps = '0;
        endcase
    end

    always_comb
    begin
        level_next       = level_reg;
        pause_next       = pause_reg;
        tone_next        = tone_reg;
        pin_next         = pin_reg;
        half_count_next  = half_count_reg;
        flip_count_next  = flip_count_reg;
        flip_limit_next  = flip_limit_reg;
        pause_count_next = pause_count_reg;

        if (item.func == FUNC_LEVEL)
        begin
            level_next      = item.new_level;
            if (item.new_level == LEVEL_OFF)
            begin
                pin_next = 1'b0;
            end
            // new train, pin keeps its level until the next flip
            flip_limit_next = {train_beeps, 1'b0};
            tone_next       = 1'b0;
            flip_count_next = '0;
            pause_next      = 1'b0;
            half_count_next = '0;
        end
        else if (level_reg != LEVEL_OFF)
        begin
            if (!pause_reg)
            begin
                half_count_next = half_count_inc;
                if (half_count_inc >= cfg.half_period_ticks)
                begin
                    half_count_next = '0;
                    flip_count_next = flip_count_inc;
                    tone_next       = ~tone_reg;
                    pin_next        = ~tone_reg;
                    if (flip_count_inc >= flip_limit_reg)
                    begin
                        flip_count_next  = '0;
                        pause_next       = 1'b1;
                        pause_count_next = '0;
                    end
                end
            end
            else
            begin
                pause_count_next = pause_count_inc;
                if (pause_count_inc >= cfg.pause_ticks)
                begin
                    pause_count_next = '0;
                    flip_limit_next  = {train_beeps, 1'b0};
                    tone_next        = 1'b0;
                    flip_count_next  = '0;
                    pause_next       = 1'b0;
                    half_count_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= LEVEL_OFF;
            pause_reg       <= 1'b0;
            tone_reg        <= 1'b0;
            pin_reg         <= 1'b0;
            half_count_reg  <= '0;
            flip_count_reg  <= '0;
            flip_limit_reg  <= '0;
            pause_count_reg <= '0;
        end
        else if (step)
        begin
            level_reg       <= level_next;
            pause_reg       <= pause_next;
            tone_reg        <= tone_next;
            pin_reg         <= pin_next;
            half_count_reg  <= half_count_next;
            flip_count_reg  <= flip_count_next;
            flip_limit_reg  <= flip_limit_next;
            pause_count_reg <= pause_count_next;
        end
    end

    assign result.buzzer_pin = pin_next;
    assign result.level_now  = level_next;
    assign result.in_pause   = pause_next;

endmodule

`default_nettype wire

[rtl/alarm_beep_pattern_generator_top.sv]
// top level of the alarm beep pattern generator
`default_nettype none

// Alarm beep pattern generator. Each req transaction is either a time tick
// or a level command; each one yields exactly one rsp transaction carrying
// the buzzer pin level, the current alarm level and the pause flag after
// that item. A nonzero level starts a train of 2N tone flips spaced by
// half_period_ticks ticks, followed by pause_ticks ticks of silence, then
// the train repeats; N comes from beeps_low/medium/high for the level.
// Level zero silences the buzzer and drives the pin low. Throughput is one
// item per clock while rsp is not stalled: an input register feeds a single
// pass of counter and compare logic whose outcome lands in the rsp register
// once that register is free, raising rsp valid. The rate is bounded by the
// combinational state update loop in abpg_core. The configuration port is
// always ready; registers should only be written while no items are in
// flight. No clearing pass is needed after reset.
module alarm_beep_pattern_generator_top
    import abpg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input item channel
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire abpg_in_t              req,
    // result channel
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output abpg_out_t                  rsp,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    abpg_cfg_t cfg;
    abpg_out_t core_result;

    // input register
    logic      req_valid_reg;
    abpg_in_t  req_reg;
    // result register
    logic      rsp_valid_reg;
    abpg_out_t rsp_reg;

    // item moves from the input register into the result register
    logic advance;

    // a held result that reports the alarm off
    logic rsp_off;

    // register writes are always taken, the port never stalls
    assign cfg_ready = 1'b1;

    abpg_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the state commits only when the result register can take the outcome
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    // input register frees up when empty or when its item moves on
    assign req_ready = !req_valid_reg || advance;

    abpg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (req_reg),
        .result (core_result)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= core_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rsp_off = rsp_valid_reg && (rsp_reg.level_now == LEVEL_OFF);

`include "alarm_beep_pattern_generator_top_assert.svh"

    // an item leaving the input register always shows up as a result
    `ABPG_ASSERT_NEXT(a_advance_fills_rsp, clk, rst_n, advance, rsp_valid_reg, "advance lost")
    // back pressure only when the input register holds an item
    `ABPG_ASSERT_NOW(a_stall_has_item, clk, rst_n, !req_ready, req_valid_reg, "stall when empty")
    // with the alarm off the pin is low
    `ABPG_ASSERT_NOW(a_off_pin_low, clk, rst_n, rsp_off, !rsp_reg.buzzer_pin, "pin high while off")
    // with the alarm off the pattern sits in the train phase
    `ABPG_ASSERT_NOW(a_off_no_pause, clk, rst_n, rsp_off, !rsp_reg.in_pause, "pause while off")

endmodule

`default_nettype wire

[tb/sv/tb_alarm_beep_pattern_generator_top.sv]
// self-checking testbench for the alarm beep pattern generator top level
`timescale 1ns / 100ps

module tb_alarm_beep_pattern_generator_top;
    import abpg_pkg::*;

    // run length, drain time and the watchdog limit
    // worst case is about 1150 items plus sender gaps and receiver stalls,
    // well under the limit below
    localparam int RANDOM_ITEMS = 113;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 50;

    // one row of the directed table: the input transaction, whether the
    // result is typed in here, and that result
    typedef struct packed {
        abpg_in_t  item;
        logic      fixed;
        abpg_out_t want;
    } dir_row_t;

    // register settings per phase: half period, pause, beeps low/medium/high
    // phase 0 drives the directed table, the rest are random phases
    localparam int NUM_SETUPS = 11;
    localparam abpg_cfg_t BEEP_SETUPS [0:NUM_SETUPS-1] = '{
        '{16'd1,     16'd2,     4'd1,  4'd2,  4'd15},  // directed: fast trains
        '{16'd2,     16'd3,     4'd1,  4'd3,  4'd5},
        '{16'd1,     16'd1,     4'd15, 4'd15, 4'd15},  // longest trains
        '{16'd0,     16'd0,     4'd0,  4'd1,  4'd2},   // zero limits and zero beeps
        '{16'd3,     16'd5,     4'd2,  4'd0,  4'd4},
        '{16'd8,     16'd2,     4'd1,  4'd1,  4'd1},   // leaves counters high ...
        '{16'd1,     16'd4,     4'd3,  4'd2,  4'd1},   // ... then the limit drops
        '{16'd65535, 16'd1,     4'd4,  4'd4,  4'd4},   // tone never flips
        '{16'd1,     16'd65535, 4'd1,  4'd2,  4'd3},   // pause never ends
        '{16'd2,     16'd2,     4'd7,  4'd9,  4'd11},
        '{16'd4,     16'd6,     4'd5,  4'd8,  4'd10}
    };

    // directed rows under phase 0 settings (half period 1, pause 2,
    // beeps 1/2/15); rows with fixed = 0 are checked against the predictor
    localparam int NUM_DIR = 25;
    localparam dir_row_t DIR_ROWS [0:NUM_DIR-1] = '{
        // tick while off, then level off: nothing moves
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b0, LEVEL_OFF,    1'b0}},
        '{'{FUNC_LEVEL, LEVEL_OFF},    1'b1, '{1'b0, LEVEL_OFF,    1'b0}},
        // low level: one beep, two flips, then the pause
        '{'{FUNC_LEVEL, LEVEL_LOW},    1'b1, '{1'b0, LEVEL_LOW,    1'b0}},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b1, LEVEL_LOW,    1'b0}},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b0, LEVEL_LOW,    1'b1}},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b0, LEVEL_LOW,    1'b1}},
        // pause runs out and the train restarts
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b0, LEVEL_LOW,    1'b0}},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b1, LEVEL_LOW,    1'b0}},
        // new level while the pin is high: pin holds until the next flip
        '{'{FUNC_LEVEL, LEVEL_HIGH},   1'b1, '{1'b1, LEVEL_HIGH,   1'b0}},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b1, LEVEL_HIGH,   1'b0}},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b0, LEVEL_HIGH,   1'b0}},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b1, '{1'b1, LEVEL_HIGH,   1'b0}},
        // level off with the pin high drives it low
        '{'{FUNC_LEVEL, LEVEL_OFF},    1'b1, '{1'b0, LEVEL_OFF,    1'b0}},
        // level field is ignored on a tick
        '{'{FUNC_TICK,  LEVEL_HIGH},   1'b1, '{1'b0, LEVEL_OFF,    1'b0}},
        '{'{FUNC_LEVEL, LEVEL_MEDIUM}, 1'b1, '{1'b0, LEVEL_MEDIUM, 1'b0}},
        '{'{FUNC_TICK,  LEVEL_HIGH},   1'b0, '0},
        '{'{FUNC_TICK,  LEVEL_MEDIUM}, 1'b0, '0},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b0, '0},
        '{'{FUNC_TICK,  LEVEL_LOW},    1'b0, '0},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b0, '0},
        // level command during the pause goes straight back to a train
        '{'{FUNC_LEVEL, LEVEL_MEDIUM}, 1'b0, '0},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b0, '0},
        '{'{FUNC_LEVEL, LEVEL_LOW},    1'b0, '0},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b0, '0},
        '{'{FUNC_TICK,  LEVEL_OFF},    1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid;
    logic                  req_ready;
    abpg_in_t              req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    abpg_out_t             rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alarm_beep_pattern_generator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow copy of the configuration registers
    logic [TICKS_W-1:0] half_limit  = HALF_PERIOD_RST;
    logic [TICKS_W-1:0] pause_limit = PAUSE_RST;
    logic [BEEPS_W-1:0] beeps_lo    = BEEPS_LOW_RST;
    logic [BEEPS_W-1:0] beeps_md    = BEEPS_MEDIUM_RST;
    logic [BEEPS_W-1:0] beeps_hi    = BEEPS_HIGH_RST;

    // predicted state of the pattern generator
    logic [LEVEL_W-1:0] cur_level  = LEVEL_OFF;
    logic               pausing    = 1'b0;
    logic               tone       = 1'b0;
    logic               pin        = 1'b0;
    logic [TICKS_W-1:0] half_count = '0;
    logic [FLIPS_W-1:0] flips      = '0;
    logic [FLIPS_W-1:0] flip_max   = '0;
    logic [TICKS_W-1:0] pause_count = '0;

    // expected buzzer results, oldest first
    abpg_out_t beep_expect_q [$];
    abpg_out_t want_rsp;

    int unsigned err_count = 0;
    int unsigned rsp_count = 0;
    int unsigned cycle_count = 0;

    // sender burst state and receiver stall pattern
    int          burst_left = 0;
    logic        bursty = 1'b0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_idx = '0;

    // start of a beep train: flip limit latched from the level's beep count
    function automatic void restart_train(logic [LEVEL_W-1:0] lvl);
        logic [BEEPS_W-1:0] n;
        case (lvl)
            LEVEL_LOW:    n = beeps_lo;
            LEVEL_MEDIUM: n = beeps_md;
            LEVEL_HIGH:   n = beeps_hi;
            default:      n = '0;
        endcase
        flip_max   = {n, 1'b0};
        tone       = 1'b0;
        flips      = '0;
        pausing    = 1'b0;
        half_count = '0;
    endfunction

    // advance the predicted generator by one transaction
    function automatic abpg_out_t beep_predict(abpg_in_t it);
        if (it.func == FUNC_TICK) begin
            if (cur_level != LEVEL_OFF) begin
                if (!pausing) begin
                    half_count = half_count + 1'b1;
                    if (half_count >= half_limit) begin
                        half_count = '0;
                        flips      = flips + 1'b1;
                        tone       = ~tone;
                        pin        = tone;
                        if (flips >= flip_max) begin
                            flips       = '0;
                            pausing     = 1'b1;
                            pause_count = '0;
                        end
                    end
                end
                else begin
                    pause_count = pause_count + 1'b1;
                    if (pause_count >= pause_limit) begin
                        pause_count = '0;
                        restart_train(cur_level);
                    end
                end
            end
        end
        else begin
            // pin only drops on level off, otherwise it waits for a flip
            tone      = 1'b0;
            cur_level = it.new_level;
            if (it.new_level == LEVEL_OFF)
                pin = 1'b0;
            restart_train(it.new_level);
        end
        return '{pin, cur_level, pausing};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (err_count < PRINT_LIMIT)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     rsp_count, what, got, want);
        err_count++;
    endtask

    // one register write transaction; the shadow copy follows at the handshake
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_HALF_PERIOD:  half_limit  = data;
            CFG_PAUSE:        pause_limit = data;
            CFG_BEEPS_LOW:    beeps_lo    = data[BEEPS_W-1:0];
            CFG_BEEPS_MEDIUM: beeps_md    = data[BEEPS_W-1:0];
            CFG_BEEPS_HIGH:   beeps_hi    = data[BEEPS_W-1:0];
            default:          ;
        endcase
    endtask

    // write every register of a setting; beep counts carry junk in the
    // upper data bits, and one write goes to an unused index
    task automatic program_setup(abpg_cfg_t s);
        logic [CFG_DATA_W-1:0] noise;
        write_reg(CFG_HALF_PERIOD, s.half_period_ticks);
        write_reg(CFG_PAUSE, s.pause_ticks);
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_BEEPS_LOW, {noise[CFG_DATA_W-1:BEEPS_W], s.beeps_low});
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_BEEPS_MEDIUM, {noise[CFG_DATA_W-1:BEEPS_W], s.beeps_medium});
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_BEEPS_HIGH, {noise[CFG_DATA_W-1:BEEPS_W], s.beeps_high});
        write_reg(CFG_IDX_W'(CFG_BEEPS_HIGH + $urandom_range(1, 3)),
                  CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // send one input transaction; a gap may open before a new burst.
    // the expectation is either the typed-in result or the predicted one
    task automatic send_item(abpg_in_t it, logic fixed, abpg_out_t fixed_want);
        abpg_out_t pred;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = bursty ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= it;
        do @(posedge clk); while (!req_ready);
        pred = beep_predict(it);
        beep_expect_q.push_back(fixed ? fixed_want : pred);
    endtask

    // drop valid and wait until every expected result is back and the
    // pipeline has had time to go quiet
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (beep_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: ready follows a rotating stall pattern
    always @(negedge clk) begin
        rsp_ready <= stall_pattern[stall_idx];
        stall_idx <= stall_idx + 1'b1;
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (beep_expect_q.size() == 0) begin
                report_mismatch("unexpected rsp transaction", int'(rsp), -1);
            end
            else begin
                want_rsp = beep_expect_q.pop_front();
                if (rsp.buzzer_pin !== want_rsp.buzzer_pin)
                    report_mismatch("buzzer_pin", rsp.buzzer_pin, want_rsp.buzzer_pin);
                if (rsp.level_now !== want_rsp.level_now)
                    report_mismatch("level_now", rsp.level_now, want_rsp.level_now);
                if (rsp.in_pause !== want_rsp.in_pause)
                    report_mismatch("in_pause", rsp.in_pause, want_rsp.in_pause);
            end
            rsp_count++;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, beep_expect_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        abpg_in_t it;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // single reset at the start of the run
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_SETUPS; p++) begin
            // every third phase runs without idling on either side
            bursty     = (p % 3 != 0);
            stall_pattern = bursty ? (16'($urandom) | 16'h0001) : 16'hFFFF;
            burst_left = 0;
            program_setup(BEEP_SETUPS[p]);
            if (p == 0) begin
                for (int i = 0; i < NUM_DIR; i++)
                    send_item(DIR_ROWS[i].item, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
            end
            else begin
                // mostly ticks, with a level command now and then so that
                // trains get to run through their flips and pauses
                for (int i = 0; i < RANDOM_ITEMS; i++) begin
                    it.func = ($urandom_range(0, 29) == 0) ? FUNC_LEVEL : FUNC_TICK;
                    it.new_level = LEVEL_W'($urandom_range(0, 3));
                    send_item(it, 1'b0, '0);
                end
            end
            settle();
        end

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
